@@ sv/msp_pkg.sv @@
// Shared types, constants and conversion tables for the multi-servo PWM block.
package msp_pkg;

    localparam int unsigned JOINTS   = 4;
    localparam int unsigned PINS     = JOINTS + 1;
    localparam int unsigned CAM_PIN  = JOINTS;
    localparam int unsigned SEL_W    = $clog2(JOINTS);
    localparam int unsigned MAX_DEG  = 180;

    localparam int unsigned DEF_BASE_START_DEG     = 90;
    localparam int unsigned DEF_SHOULDER_START_DEG = 90;
    localparam int unsigned DEF_ELBOW_START_DEG    = 90;
    localparam int unsigned DEF_WRIST_START_DEG    = 90;

    typedef logic [7:0]  deg_t;
    typedef logic [7:0]  steps_t;
    typedef logic [10:0] count_t;
    typedef logic [11:0] sum_t;

    localparam count_t FRAME_LAST   = 11'd2000;
    localparam count_t PULSE_WINDOW = 11'd1750;
    localparam count_t CAM_EDGE     = 11'd1845;
    localparam sum_t   PULSE_END    = 12'd1950;

    // Command codes carried in the cmd field.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef steps_t steps_rom_t [256];
    typedef deg_t   deg_rom_t   [256];

    typedef struct packed {
        logic   tick;
        logic   wrap;
        logic   window;
        count_t count;
    } tick_t;

    typedef struct packed {
        logic   pin;
        logic   at_target;
        steps_t steps;
    } lane_t;

    typedef struct packed {
        logic [PINS-1:0] pin_levels;
        logic            all_at_target;
        deg_t            joint_degrees;
    } result_t;

    // Angles above full travel saturate before conversion to steps.
    function automatic steps_t deg_to_steps_const(int unsigned deg);
        int unsigned d;
        d = (deg > MAX_DEG) ? MAX_DEG : deg;
        return steps_t'((d * 10) / 9);
    endfunction

    function automatic steps_rom_t build_deg_to_steps();
        steps_rom_t rom;
        for (int i = 0; i < 256; i++)
        begin
            rom[i] = deg_to_steps_const(i);
        end
        return rom;
    endfunction

    function automatic deg_rom_t build_steps_to_deg();
        deg_rom_t rom;
        for (int i = 0; i < 256; i++)
        begin
            rom[i] = deg_t'((i * 9) / 10);
        end
        return rom;
    endfunction

    localparam steps_rom_t DEG_TO_STEPS = build_deg_to_steps();
    localparam deg_rom_t   STEPS_TO_DEG = build_steps_to_deg();

endpackage

@@ sv/msp_item_if.sv @@
// Input channel: one command word with four joint targets and a joint select.
interface msp_item_if;
    import msp_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    deg_t             target_base;
    deg_t             target_shoulder;
    deg_t             target_elbow;
    deg_t             target_wrist;
    logic [SEL_W-1:0] read_joint;

    modport source (
        output valid, cmd, target_base, target_shoulder, target_elbow, target_wrist,
               read_joint,
        input  ready
    );

    modport sink (
        input  valid, cmd, target_base, target_shoulder, target_elbow, target_wrist,
               read_joint,
        output ready
    );
endinterface

@@ sv/msp_result_if.sv @@
// Output channel: pin levels, at-target flag and the selected joint angle.
interface msp_result_if;
    import msp_pkg::*;

    logic            valid;
    logic            ready;
    logic [PINS-1:0] pin_levels;
    logic            all_at_target;
    deg_t            joint_degrees;

    modport source (
        output valid, pin_levels, all_at_target, joint_degrees,
        input  ready
    );

    modport sink (
        input  valid, pin_levels, all_at_target, joint_degrees,
        output ready
    );
endinterface

@@ sv/msp_frame.sv @@
// Shared PWM frame counter and the camera pin latch.
module msp_frame (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tick,
    output msp_pkg::tick_t tinfo,
    output logic           cam_pin
);
    import msp_pkg::*;

    count_t count_reg;
    count_t count_next;
    logic   cam_reg;
    logic   cam_next;
    count_t count_val;
    logic   wrap;
    logic   window;

    // The counter runs past the last frame value once, then wraps and clears the pins.
    assign wrap      = (count_reg > FRAME_LAST);
    assign count_val = wrap ? '0 : count_reg + 11'd1;
    assign window    = (count_val > PULSE_WINDOW);

    always_comb
    begin
        count_next = count_reg;
        cam_next   = cam_reg;
        if (tick)
        begin
            count_next = count_val;
            if (wrap)
            begin
                cam_next = 1'b0;
            end
            else if (window && (count_val > CAM_EDGE))
            begin
                cam_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cam_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            cam_reg   <= cam_next;
        end
    end

    assign tinfo.tick   = tick;
    assign tinfo.wrap   = wrap;
    assign tinfo.window = window;
    assign tinfo.count  = count_val;
    assign cam_pin      = cam_next;
endmodule

@@ sv/msp_lane.sv @@
// One joint lane: position register, one-step slew and pulse pin latch.
module msp_lane #(
    parameter int unsigned START_DEG = msp_pkg::DEF_BASE_START_DEG
) (
    input  logic           clk,
    input  logic           rst_n,
    input  msp_pkg::tick_t tinfo,
    input  logic           step,
    input  msp_pkg::deg_t  target,
    output msp_pkg::lane_t lane
);
    import msp_pkg::*;

    localparam steps_t START_STEPS = deg_to_steps_const(START_DEG);

    steps_t steps_reg;
    steps_t steps_next;
    logic   pin_reg;
    logic   pin_next;
    steps_t tgt;
    sum_t   pulse_sum;

    assign tgt       = DEG_TO_STEPS[target];
    assign pulse_sum = {1'b0, tinfo.count} + {4'b0, steps_reg};

    always_comb
    begin
        steps_next = steps_reg;
        if (step)
        begin
            if (tgt < steps_reg)
            begin
                steps_next = steps_reg - 8'd1;
            end
            else if (tgt > steps_reg)
            begin
                steps_next = steps_reg + 8'd1;
            end
        end
    end

    // A larger position raises the pin earlier in the window, so the pulse is wider.
    always_comb
    begin
        pin_next = pin_reg;
        if (tinfo.tick)
        begin
            if (tinfo.wrap)
            begin
                pin_next = 1'b0;
            end
            else if (tinfo.window && (pulse_sum > PULSE_END))
            begin
                pin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= START_STEPS;
            pin_reg   <= 1'b0;
        end
        else
        begin
            steps_reg <= steps_next;
            pin_reg   <= pin_next;
        end
    end

    assign lane.pin       = pin_next;
    assign lane.at_target = (steps_next == tgt);
    assign lane.steps     = steps_next;
endmodule

@@ sv/msp_out.sv @@
// Merges the lane results into one word and buffers it with a skid stage.
module msp_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  msp_pkg::lane_t              lanes [msp_pkg::JOINTS],
    input  logic                        cam_pin,
    input  logic [msp_pkg::SEL_W-1:0]   read_joint,
    output logic                        ready_in,
    msp_result_if.source                result
);
    import msp_pkg::*;

    result_t merged;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    take;

    always_comb
    begin
        merged.all_at_target = 1'b1;
        for (int i = 0; i < JOINTS; i++)
        begin
            merged.pin_levels[i] = lanes[i].pin;
            merged.all_at_target = merged.all_at_target & lanes[i].at_target;
        end
        merged.pin_levels[CAM_PIN] = cam_pin;
        merged.joint_degrees       = STEPS_TO_DEG[lanes[read_joint].steps];
    end

    assign take     = result.valid && result.ready;
    assign ready_in = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        // A new word goes to the output register when it is free, else to the skid.
        if (load)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = merged;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = merged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.pin_levels    = out_data_reg.pin_levels;
    assign result.all_at_target = out_data_reg.all_at_target;
    assign result.joint_degrees = out_data_reg.joint_degrees;
endmodule

@@ sv/multi_servo_pwm_with_slew.sv @@
// Top level of the five-pin servo PWM generator with per-joint slew.
//
// The item channel carries a command word: cmd selects a PWM tick or a slew
// step, four target angles in degrees (values above 180 count as 180) and the
// joint whose position is reported. Every accepted word produces exactly one
// word on the result channel: the five pin levels, the all-at-target flag and
// the selected joint's position in degrees, all taken after the word's update.
// Four joint lanes and the frame counter update in parallel in the cycle the
// word is accepted; the result is registered for output. One word is accepted
// per cycle, limited only by the two-entry output buffer (output register plus
// skid register). When the receiver stalls, the skid holds one more word and
// ready drops once both entries are full; no word is lost or repeated.
// Reset clears the frame counter and all pins, places every joint at its start
// angle converted to steps, and empties the output buffer.
module multi_servo_pwm_with_slew #(
    parameter int unsigned BASE_START_DEG     = msp_pkg::DEF_BASE_START_DEG,
    parameter int unsigned SHOULDER_START_DEG = msp_pkg::DEF_SHOULDER_START_DEG,
    parameter int unsigned ELBOW_START_DEG    = msp_pkg::DEF_ELBOW_START_DEG,
    parameter int unsigned WRIST_START_DEG    = msp_pkg::DEF_WRIST_START_DEG
) (
    input  logic         clk,
    input  logic         rst_n,
    msp_item_if.sink     item,
    msp_result_if.source result
);
    import msp_pkg::*;

    localparam int unsigned START_DEGS [JOINTS] = '{
        BASE_START_DEG, SHOULDER_START_DEG, ELBOW_START_DEG, WRIST_START_DEG
    };

    logic  ready_in;
    logic  accept;
    logic  tick;
    logic  step;
    tick_t tinfo;
    logic  cam_pin;
    lane_t lanes [JOINTS];
    deg_t  targets [JOINTS];

    assign item.ready = ready_in;
    assign accept     = item.valid && ready_in;
    assign tick       = accept && (item.cmd == CMD_TICK);
    assign step       = accept && (item.cmd == CMD_STEP);

    assign targets[0] = item.target_base;
    assign targets[1] = item.target_shoulder;
    assign targets[2] = item.target_elbow;
    assign targets[3] = item.target_wrist;

    msp_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .tinfo   (tinfo),
        .cam_pin (cam_pin)
    );

    for (genvar g = 0; g < JOINTS; g++)
    begin : g_lane
        msp_lane #(
            .START_DEG (START_DEGS[g])
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .tinfo  (tinfo),
            .step   (step),
            .target (targets[g]),
            .lane   (lanes[g])
        );
    end

    msp_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .lanes      (lanes),
        .cam_pin    (cam_pin),
        .read_joint (item.read_joint),
        .ready_in   (ready_in),
        .result     (result)
    );
endmodule
